// File: rtl/blr_pkg.sv
// Shared types and constants for the bitmask line rasterizer.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package blr_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam int COORD_W     = 9;
   localparam int PEN_W       = 8;
   localparam int CFG_W       = 10;
   localparam int SIZE_W      = 13;
   localparam int ERR_W       = 12;
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;

   // Field offsets inside req_tdata.
   localparam int REQ_SX_LSB    = 0;
   localparam int REQ_SY_LSB    = REQ_SX_LSB + COORD_W;
   localparam int REQ_EX_LSB    = REQ_SY_LSB + COORD_W;
   localparam int REQ_EY_LSB    = REQ_EX_LSB + COORD_W;
   localparam int REQ_PEN_LSB   = REQ_EY_LSB + COORD_W;
   localparam int REQ_THICK_BIT = REQ_PEN_LSB + PEN_W;

   // Bit of range_error inside rsp_tdata; read_data sits below it.
   localparam int RSP_ERR_BIT = PEN_W;

   localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      NBR_CENTER,
      NBR_LEFT,
      NBR_RIGHT,
      NBR_UP,
      NBR_DOWN
   } nbr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SETUP,
      ST_PLOT_C,
      ST_PLOT_L,
      ST_PLOT_R,
      ST_PLOT_U,
      ST_PLOT_D,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic    load_item;
      logic    mem_write;
      logic    mem_read;
      logic    addr_point;
      logic    line_init;
      logic    line_step;
      nbr_type nbr;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              start_ok;
      logic              all_ok;
      logic              thick;
      logic              last_point;
   } status_type;

endpackage

// File: rtl/blr_ctrl.sv
// Controller state machine of the bitmask line rasterizer.
// Sequences item checks, pixel accesses and line plotting; owns rsp_tvalid.
// Depends on blr_pkg.
module blr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  blr_pkg::status_type    status,
   output blr_pkg::cmd_type       cmd
);

   blr_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.nbr    = blr_pkg::NBR_CENTER;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         blr_pkg::ST_IDLE: begin
            // No transaction is taken while reset is held.
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = blr_pkg::ST_CHECK;
            end
         end
         blr_pkg::ST_CHECK: begin
            state_in = blr_pkg::ST_RESULT;
            case (status.func)
               blr_pkg::FUNC_WRITE: cmd.mem_write = status.start_ok;
               blr_pkg::FUNC_READ:  cmd.mem_read  = status.start_ok;
               blr_pkg::FUNC_DRAW: begin
                  if (status.all_ok) begin
                     state_in = blr_pkg::ST_SETUP;
                  end
               end
               default: ;
            endcase
         end
         blr_pkg::ST_SETUP: begin
            cmd.line_init = 1'b1;
            state_in      = blr_pkg::ST_PLOT_C;
         end
         blr_pkg::ST_PLOT_C: begin
            cmd.mem_write  = 1'b1;
            cmd.addr_point = 1'b1;
            if (status.thick) begin
               state_in = blr_pkg::ST_PLOT_L;
            end else if (status.last_point) begin
               state_in = blr_pkg::ST_RESULT;
            end else begin
               cmd.line_step = 1'b1;
            end
         end
         blr_pkg::ST_PLOT_L: begin
            cmd.mem_write  = 1'b1;
            cmd.addr_point = 1'b1;
            cmd.nbr        = blr_pkg::NBR_LEFT;
            state_in       = blr_pkg::ST_PLOT_R;
         end
         blr_pkg::ST_PLOT_R: begin
            cmd.mem_write  = 1'b1;
            cmd.addr_point = 1'b1;
            cmd.nbr        = blr_pkg::NBR_RIGHT;
            state_in       = blr_pkg::ST_PLOT_U;
         end
         blr_pkg::ST_PLOT_U: begin
            cmd.mem_write  = 1'b1;
            cmd.addr_point = 1'b1;
            cmd.nbr        = blr_pkg::NBR_UP;
            state_in       = blr_pkg::ST_PLOT_D;
         end
         blr_pkg::ST_PLOT_D: begin
            cmd.mem_write  = 1'b1;
            cmd.addr_point = 1'b1;
            cmd.nbr        = blr_pkg::NBR_DOWN;
            if (status.last_point) begin
               state_in = blr_pkg::ST_RESULT;
            end else begin
               cmd.line_step = 1'b1;
               state_in      = blr_pkg::ST_PLOT_C;
            end
         end
         blr_pkg::ST_RESULT: begin
            // The output register is free when empty or emptied at this edge.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = blr_pkg::ST_IDLE;
            end
         end
         default: state_in = blr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/blr_datapath.sv
// Datapath of the bitmask line rasterizer: size registers, item latch,
// integer line stepper, pixel memory and result register.
// Depends on blr_pkg; driven by blr_ctrl commands.
module blr_datapath #(
   parameter int MAX_WIDTH  = blr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = blr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [blr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [blr_pkg::CFG_W-1:0]           csr_wdata,
   input  logic [blr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [blr_pkg::FUNC_W-1:0]          req_tuser,
   input  blr_pkg::cmd_type                    cmd,
   output blr_pkg::status_type                 status,
   output logic [blr_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CW     = blr_pkg::COORD_W;
   localparam int SW     = blr_pkg::SIZE_W;
   localparam int EW     = blr_pkg::ERR_W;
   localparam int PW     = blr_pkg::PEN_W;

   logic [blr_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [SW-1:0]             w_eff, h_eff;

   logic [blr_pkg::FUNC_W-1:0] func_ff;
   logic [CW-1:0]              sx_ff, sy_ff, ex_ff, ey_ff;
   logic [PW-1:0]              pen_ff;
   logic                       thick_ff;
   logic                       start_ok, end_ok;

   logic signed [CW:0]   dx, dy, db;
   logic [CW-1:0]        adx, ady, n_len, a0, b0;
   logic                 xmajor, dx_pos, dy_pos;

   logic [CW-1:0]        maj_ff, maj_in, min_ff, min_in, cnt_ff, cnt_in;
   logic signed [EW-1:0] r_ff, r_in, db2_ff, db2_in, n2_ff, n2_in, r_sum;
   logic                 xmajor_ff, xmajor_in;

   logic [CW-1:0]        pt_x, pt_y, wx, wy, x_sel, y_sel;
   logic [ADDR_W-1:0]    addr;
   logic [PW-1:0]        mem [DEPTH];
   logic [PW-1:0]        rd_data_ff;

   logic [PW-1:0]        read_data_ff, read_data_in;
   logic                 range_error_ff, range_error_in;

   // Size registers; out-of-range values are clamped where they are used.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blr_pkg::SIZE_RESET;
         height_ff <= blr_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == blr_pkg::CSR_ACTIVE_WIDTH) begin
            width_ff <= csr_wdata;
         end else begin
            height_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = SW'(1);
      end else if (SW'(width_ff) > SW'(MAX_WIDTH)) begin
         w_eff = SW'(MAX_WIDTH);
      end else begin
         w_eff = SW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = SW'(1);
      end else if (SW'(height_ff) > SW'(MAX_HEIGHT)) begin
         h_eff = SW'(MAX_HEIGHT);
      end else begin
         h_eff = SW'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff  <= req_tuser;
         sx_ff    <= req_tdata[blr_pkg::REQ_SX_LSB +: CW];
         sy_ff    <= req_tdata[blr_pkg::REQ_SY_LSB +: CW];
         ex_ff    <= req_tdata[blr_pkg::REQ_EX_LSB +: CW];
         ey_ff    <= req_tdata[blr_pkg::REQ_EY_LSB +: CW];
         pen_ff   <= req_tdata[blr_pkg::REQ_PEN_LSB +: PW];
         thick_ff <= req_tdata[blr_pkg::REQ_THICK_BIT];
      end
   end

   assign start_ok = (SW'(sx_ff) < w_eff) && (SW'(sy_ff) < h_eff);
   assign end_ok   = (SW'(ex_ff) < w_eff) && (SW'(ey_ff) < h_eff);

   // Line setup: order the end points so that the major axis increases.
   always_comb begin
      dx     = $signed({1'b0, ex_ff}) - $signed({1'b0, sx_ff});
      dy     = $signed({1'b0, ey_ff}) - $signed({1'b0, sy_ff});
      adx    = dx[CW] ? CW'(-dx) : CW'(dx);
      ady    = dy[CW] ? CW'(-dy) : CW'(dy);
      dx_pos = !dx[CW] && (dx != '0);
      dy_pos = !dy[CW] && (dy != '0);
      xmajor = adx >= ady;
      if (xmajor) begin
         n_len = adx;
         a0    = dx_pos ? sx_ff : ex_ff;
         b0    = dx_pos ? sy_ff : ey_ff;
         db    = dx_pos ? dy : -dy;
      end else begin
         n_len = ady;
         a0    = dy_pos ? sy_ff : ey_ff;
         b0    = dy_pos ? sx_ff : ex_ff;
         db    = dy_pos ? dx : -dx;
      end
   end

   // The minor coordinate is b0 + q with q = floor((2*db*k + n) / (2*n));
   // r is the running remainder, kept in [0, 2n).
   always_comb begin
      maj_in    = maj_ff;
      min_in    = min_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      db2_in    = db2_ff;
      n2_in     = n2_ff;
      xmajor_in = xmajor_ff;
      r_sum     = r_ff + db2_ff;
      if (cmd.line_init) begin
         maj_in    = a0;
         min_in    = b0;
         cnt_in    = n_len;
         r_in      = $signed({{(EW-CW){1'b0}}, n_len});
         db2_in    = $signed({{(EW-CW-2){db[CW]}}, db, 1'b0});
         n2_in     = $signed({{(EW-CW-1){1'b0}}, n_len, 1'b0});
         xmajor_in = xmajor;
      end else if (cmd.line_step) begin
         maj_in = maj_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
         if (r_sum >= n2_ff) begin
            r_in   = r_sum - n2_ff;
            min_in = min_ff + 1'b1;
         end else if (r_sum < 0) begin
            r_in   = r_sum + n2_ff;
            min_in = min_ff - 1'b1;
         end else begin
            r_in = r_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      maj_ff    <= maj_in;
      min_ff    <= min_in;
      cnt_ff    <= cnt_in;
      r_ff      <= r_in;
      db2_ff    <= db2_in;
      n2_ff     <= n2_in;
      xmajor_ff <= xmajor_in;
   end

   assign pt_x = xmajor_ff ? maj_ff : min_ff;
   assign pt_y = xmajor_ff ? min_ff : maj_ff;

   // A neighbor outside the active area falls back to the point itself,
   // which rewrites the same value.
   always_comb begin
      wx = pt_x;
      wy = pt_y;
      unique case (cmd.nbr)
         blr_pkg::NBR_LEFT:  if (pt_x != '0) wx = pt_x - 1'b1;
         blr_pkg::NBR_RIGHT: if (SW'(pt_x) + SW'(1) < w_eff) wx = pt_x + 1'b1;
         blr_pkg::NBR_UP:    if (pt_y != '0) wy = pt_y - 1'b1;
         blr_pkg::NBR_DOWN:  if (SW'(pt_y) + SW'(1) < h_eff) wy = pt_y + 1'b1;
         default: ;
      endcase
   end

   assign x_sel = cmd.addr_point ? wx : sx_ff;
   assign y_sel = cmd.addr_point ? wy : sy_ff;
   assign addr  = ADDR_W'(y_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_sel);

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[addr] <= pen_ff;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_comb begin
      read_data_in = (func_ff == blr_pkg::FUNC_READ && start_ok) ? rd_data_ff : '0;
      case (func_ff) inside
         blr_pkg::FUNC_WRITE, blr_pkg::FUNC_READ: range_error_in = !start_ok;
         blr_pkg::FUNC_DRAW:                      range_error_in = !(start_ok && end_ok);
         default:                                 range_error_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         read_data_ff   <= read_data_in;
         range_error_ff <= range_error_in;
      end
   end

   assign rsp_tdata = {{(blr_pkg::RSP_DATA_W-PW-1){1'b0}}, range_error_ff, read_data_ff};

   assign status.func       = func_ff;
   assign status.start_ok   = start_ok;
   assign status.all_ok     = start_ok && end_ok;
   assign status.thick      = thick_ff;
   assign status.last_point = (cnt_ff == '0);

endmodule

// File: rtl/bitmask_line_rasterizer_core.sv
// Top level of the bitmask line rasterizer: byte-per-pixel image with
// pixel write, pixel read and line drawing. Instantiates blr_ctrl and
// blr_datapath; depends on blr_pkg.
//
//   channel | direction | tdata (low bit first)                         | tuser
//   req_    | in        | start_x, start_y, end_x, end_y, pen_value, thick | func
//   rsp_    | out       | read_data, range_error                        | -
//   csr_    | in        | write enable, index (0 width, 1 height), data | -
//
// A write, a read or a rejected item runs the check and result states; a draw also
// runs setup, then writes its n + 1 points and, when thick, their four neighbors,
// where n is the longer of the two extents, via the single write port of the pixel
// memory. One item is worked on at a time. Reset sets both sizes to 512 and does
// not clear the pixel memory. A stalled result waits in the output register; the
// next item is still accepted and completes once that register has been taken.
module bitmask_line_rasterizer_core #(
   parameter int MAX_WIDTH  = blr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = blr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_x[8:0], start_y[17:9], end_x[26:18], end_y[35:27],
   // pen_value[43:36], thick[44], zero fill[47:45]
   input  logic [blr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // func[1:0]
   input  logic [blr_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_data[7:0], range_error[8], zero fill[15:9]
   output logic [blr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [blr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [blr_pkg::CFG_W-1:0]           csr_wdata
);

   blr_pkg::cmd_type    cmd;
   blr_pkg::status_type status;

   blr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   blr_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: rtl/blr_checker.sv
// Port-level checker for the bitmask line rasterizer, bound to the top level.
// Depends on blr_pkg.
module blr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [blr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // One item at a time: the block is busy right after a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted transaction");

   // Results never appear in the cycle after an accept.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared one cycle after acceptance");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[blr_pkg::RSP_ERR_BIT] |->
         rsp_tdata[blr_pkg::PEN_W-1:0] == '0)
      else $error("range error reported with nonzero read data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind bitmask_line_rasterizer_core blr_checker u_blr_checker (.*);

// File: bench/bitmask_line_rasterizer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bitmask_line_rasterizer_core: pixel writes, reads and
// line draws against an image model kept in a scoreboard class, over several sizes.
// Depends on blr_pkg and the RTL of the rasterizer core.
module bitmask_line_rasterizer_core_tb;

   localparam int IMG_W = blr_pkg::MAX_WIDTH_DEF;
   localparam int IMG_H = blr_pkg::MAX_HEIGHT_DEF;
   localparam int CW    = blr_pkg::COORD_W;
   localparam int PW    = blr_pkg::PEN_W;
   localparam int CFGW  = blr_pkg::CFG_W;
   localparam int PHASES = 8;
   localparam int RANDOM_PER_PHASE = 26;
   localparam logic [blr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [blr_pkg::FUNC_W-1:0]  func;
      logic [blr_pkg::COORD_W-1:0] sx;
      logic [blr_pkg::COORD_W-1:0] sy;
      logic [blr_pkg::COORD_W-1:0] ex;
      logic [blr_pkg::COORD_W-1:0] ey;
      logic [blr_pkg::PEN_W-1:0]   pen;
      logic                        thick;
   } raster_cmd_type;

   typedef struct packed {
      logic [blr_pkg::PEN_W-1:0] read_data;
      logic                      range_error;
   } raster_rsp_type;

   class raster_scoreboard_type;
      bit [blr_pkg::PEN_W-1:0] image [IMG_W*IMG_H];
      bit             painted [IMG_W*IMG_H];
      int             painted_q[$];
      bit [blr_pkg::CFG_W-1:0] width_cfg;
      bit [blr_pkg::CFG_W-1:0] height_cfg;
      raster_rsp_type expected_q[$];
      int errors, checked, accepted, draws, reads, rejects;

      function new();
         width_cfg = blr_pkg::SIZE_RESET;
         height_cfg = blr_pkg::SIZE_RESET;
         errors = 0;
         checked = 0;
         accepted = 0;
         draws = 0;
         reads = 0;
         rejects = 0;
      endfunction

      function void set_size(logic [blr_pkg::CSR_INDEX_W-1:0] idx,
                             logic [blr_pkg::CFG_W-1:0] value);
         if (idx == blr_pkg::CSR_ACTIVE_WIDTH) width_cfg = value;
         else height_cfg = value;
      endfunction

      // A size of zero behaves as one; anything above the image behaves as its maximum.
      function int clamp_size(bit [blr_pkg::CFG_W-1:0] v, int maxv);
         if (v == 0) return 1;
         if (int'(v) > maxv) return maxv;
         return int'(v);
      endfunction

      function int cur_width();
         return clamp_size(width_cfg, IMG_W);
      endfunction

      function int cur_height();
         return clamp_size(height_cfg, IMG_H);
      endfunction

      function bit is_painted(int x, int y);
         return painted[y*IMG_W + x];
      endfunction

      function void paint_pixel(int x, int y, bit [blr_pkg::PEN_W-1:0] v);
         int a;
         if (x < IMG_W && y < IMG_H) begin
            a = y*IMG_W + x;
            if (!painted[a]) begin
               painted[a] = 1'b1;
               painted_q.insert(painted_q.size(), a);
            end
            image[a] = v;
         end
      endfunction

      function void paint_spot(int x, int y, bit [blr_pkg::PEN_W-1:0] v, bit thick,
                               int w, int h);
         paint_pixel(x, y, v);
         if (thick) begin
            if (x > 0) paint_pixel(x - 1, y, v);
            if (x + 1 < w) paint_pixel(x + 1, y, v);
            if (y > 0) paint_pixel(x, y - 1, v);
            if (y + 1 < h) paint_pixel(x, y + 1, v);
         end
      endfunction

      function int floor_div(int num, int den);
         if (num >= 0) return num / den;
         return -((-num + den - 1) / den);
      endfunction

      // Walks the major axis upward; the minor coordinate is rounded exactly,
      // with a half rounding up.
      function void trace_line(int x0, int y0, int x1, int y1, bit [blr_pkg::PEN_W-1:0] v,
                               bit thick, int w, int h);
         int dx, dy, adx, ady, n, a0, b0, db, m;
         bit xmajor;
         dx = x1 - x0;
         dy = y1 - y0;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         xmajor = adx >= ady;
         paint_spot(x0, y0, v, thick, w, h);
         if (dx == 0 && dy == 0) return;
         if (xmajor) begin
            n = adx;
            if (dx > 0) begin a0 = x0; b0 = y0; db = dy; end
            else begin a0 = x1; b0 = y1; db = -dy; end
         end else begin
            n = ady;
            if (dy > 0) begin a0 = y0; b0 = x0; db = dx; end
            else begin a0 = y1; b0 = x1; db = -dx; end
         end
         for (int k = 0; k <= n; k++) begin
            m = b0 + floor_div(2*db*k + n, 2*n);
            if (xmajor) paint_spot(a0 + k, m, v, thick, w, h);
            else paint_spot(m, a0 + k, v, thick, w, h);
         end
      endfunction

      function void note_request(raster_cmd_type c);
         raster_rsp_type r;
         int w, h;
         bit start_ok;
         w = cur_width();
         h = cur_height();
         r.read_data = '0;
         r.range_error = 1'b0;
         start_ok = int'(c.sx) < w && int'(c.sy) < h;
         accepted++;
         case (c.func)
            blr_pkg::FUNC_WRITE: begin
               if (start_ok) paint_pixel(int'(c.sx), int'(c.sy), c.pen);
               else r.range_error = 1'b1;
            end
            blr_pkg::FUNC_READ: begin
               reads++;
               if (start_ok) r.read_data = image[int'(c.sy)*IMG_W + int'(c.sx)];
               else r.range_error = 1'b1;
            end
            blr_pkg::FUNC_DRAW: begin
               draws++;
               if (start_ok && int'(c.ex) < w && int'(c.ey) < h)
                  trace_line(int'(c.sx), int'(c.sy), int'(c.ex), int'(c.ey), c.pen,
                             c.thick, w, h);
               else r.range_error = 1'b1;
            end
            default: ;
         endcase
         if (r.range_error) rejects++;
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void check_response(logic [blr_pkg::RSP_DATA_W-1:0] tdata);
         raster_rsp_type want, got;
         got.read_data = tdata[blr_pkg::PEN_W-1:0];
         got.range_error = tdata[blr_pkg::RSP_ERR_BIT];
         if (expected_q.size() == 0) begin
            $display("%0t ns: result with nothing expected, expected none, got data %02h err %0b",
                     $time, got.read_data, got.range_error);
            errors++;
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         checked++;
         if (got.read_data !== want.read_data) begin
            $display("%0t ns: read_data mismatch, expected %02h, got %02h",
                     $time, want.read_data, got.read_data);
            errors++;
         end
         if (got.range_error !== want.range_error) begin
            $display("%0t ns: range_error mismatch, expected %0b, got %0b",
                     $time, want.range_error, got.range_error);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [blr_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [blr_pkg::FUNC_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [blr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en;
   logic [blr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [blr_pkg::CFG_W-1:0] csr_wdata;

   bit req_gaps_on;
   bit rsp_stalls_on;
   raster_scoreboard_type sb = new();

   bitmask_line_rasterizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function raster_cmd_type make_cmd(logic [blr_pkg::FUNC_W-1:0] func, int sx, int sy,
                                     int ex, int ey, logic [blr_pkg::PEN_W-1:0] pen,
                                     logic thick);
      raster_cmd_type c;
      c.func = func;
      c.sx = CW'(sx);
      c.sy = CW'(sy);
      c.ex = CW'(ex);
      c.ey = CW'(ey);
      c.pen = pen;
      c.thick = thick;
      return c;
   endfunction

   // Reads only ever target a painted pixel or an address outside the active area.
   function raster_cmd_type random_cmd();
      raster_cmd_type c;
      int w, h, pick, x, y, a;
      bit found;
      w = sb.cur_width();
      h = sb.cur_height();
      c = make_cmd(blr_pkg::FUNC_WRITE, int'($urandom_range(0, IMG_W-1)),
                   int'($urandom_range(0, IMG_H-1)), int'($urandom_range(0, IMG_W-1)),
                   int'($urandom_range(0, IMG_H-1)), PW'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      pick = int'($urandom_range(0, 99));
      if (pick < 25) begin
         if ($urandom_range(0, 9) != 0) begin
            c.sx = CW'($urandom_range(0, w-1));
            c.sy = CW'($urandom_range(0, h-1));
         end
      end else if (pick < 47) begin
         c.func = blr_pkg::FUNC_READ;
         found = 1'b0;
         if ($urandom_range(0, 4) != 0 && sb.painted_q.size() > 0) begin
            for (int t = 0; t < 16 && !found; t++) begin
               a = sb.painted_q[$urandom_range(0, sb.painted_q.size()-1)];
               c.sx = CW'(a % IMG_W);
               c.sy = CW'(a / IMG_W);
               found = int'(c.sx) < w && int'(c.sy) < h;
            end
         end else if (int'(c.sx) < w && int'(c.sy) < h &&
                      !sb.is_painted(int'(c.sx), int'(c.sy))) begin
            if (w < IMG_W) c.sx = CW'($urandom_range(w, IMG_W-1));
            else if (h < IMG_H) c.sy = CW'($urandom_range(h, IMG_H-1));
            else c.func = blr_pkg::FUNC_WRITE;
         end
      end else if (pick < 95) begin
         c.func = blr_pkg::FUNC_DRAW;
         if ($urandom_range(0, 9) != 0) begin
            c.sx = CW'($urandom_range(0, w-1));
            c.sy = CW'($urandom_range(0, h-1));
            if ($urandom_range(0, 24) == 0) begin
               c.ex = CW'($urandom_range(0, w-1));
               c.ey = CW'($urandom_range(0, h-1));
            end else begin
               // Short lines keep the run fast while still taking every direction.
               x = int'(c.sx) + int'($urandom_range(0, 24)) - 12;
               y = int'(c.sy) + int'($urandom_range(0, 24)) - 12;
               if (x < 0) x = 0;
               if (x > w-1) x = w-1;
               if (y < 0) y = 0;
               if (y > h-1) y = h-1;
               c.ex = CW'(x);
               c.ey = CW'(y);
            end
         end
      end else begin
         c.func = FUNC_UNUSED;
      end
      return c;
   endfunction

   task automatic send_cmd(raster_cmd_type c);
      int gap;
      gap = req_gaps_on ? int'($urandom_range(0, 13)) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.func;
      req_tdata <= {{(blr_pkg::REQ_DATA_W-blr_pkg::REQ_THICK_BIT-1){1'b0}}, c.thick, c.pen,
                    c.ey, c.ex, c.sy, c.sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(c);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_sizes(logic [blr_pkg::CFG_W-1:0] w, logic [blr_pkg::CFG_W-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= blr_pkg::CSR_ACTIVE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.set_size(blr_pkg::CSR_ACTIVE_WIDTH, w);
      csr_index <= blr_pkg::CSR_ACTIVE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.set_size(blr_pkg::CSR_ACTIVE_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int phase_w [PHASES];
      int phase_h [PHASES];
      phase_w = '{512, 0, 1023, 1, 600, 37, 257, 512};
      phase_h = '{512, 0, 3, 1023, 200, 512, 129, 512};
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= blr_pkg::FUNC_WRITE;
      csr_wr_en <= 1'b0;
      csr_index <= blr_pkg::CSR_ACTIVE_WIDTH;
      csr_wdata <= '0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners, the unused selector, rounding ties in both directions and long lines.
      send_cmd(make_cmd(blr_pkg::FUNC_WRITE, 0, 0, 511, 511, 8'h00, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_WRITE, 511, 511, 0, 0, 8'hFF, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_WRITE, 511, 0, 0, 0, 8'hA5, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_WRITE, 0, 511, 0, 0, 8'h5A, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 0, 0, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 511, 511, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 511, 0, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 0, 511, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(FUNC_UNUSED, 511, 511, 511, 511, 8'hFF, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 5, 5, 5, 5, 8'h11, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 10, 10, 12, 11, 8'h22, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 11, 11, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 12, 21, 10, 20, 8'h23, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 11, 21, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 40, 41, 42, 40, 8'h24, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 41, 41, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 30, 40, 27, 30, 8'h25, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 0, 100, 511, 100, 8'h33, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 200, 511, 200, 0, 8'h44, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 511, 511, 0, 0, 8'hC3, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_DRAW, 0, 0, 0, 0, 8'h77, 1'b1));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 1, 0, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 0, 1, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 511, 510, 0, 0, 8'h00, 1'b0));
      send_cmd(make_cmd(blr_pkg::FUNC_READ, 28, 33, 0, 0, 8'h00, 1'b0));

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            // Sizes change only with the block idle.
            drain();
            set_sizes(CFGW'(phase_w[p]), CFGW'(phase_h[p]));
         end
         req_gaps_on = (p % 4 == 0) || (p % 4 == 1);
         rsp_stalls_on = (p % 4 == 0) || (p % 4 == 2);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) send_cmd(random_cmd());
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d transactions (%0d draws, %0d reads, %0d rejected) over %0d sizes.",
               sb.accepted, sb.draws, sb.reads, sb.rejects, PHASES);
      $display("Checked %0d results, %0d pixels painted.", sb.checked, sb.painted_q.size());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_stalls_on ? int'($urandom_range(0, 13)) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_response(rsp_tdata);
      end
   end

   // Well above the slowest legal run, where every transaction is a full thick diagonal.
   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
